[design/page_framebuffer_tile_blit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the frame store blit RTL
// Each macro expands to one labeled concurrent assertion on the rising clock,
// disabled while the asynchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_TILE_BLIT_DEFINES_SVH
`define PAGE_FRAMEBUFFER_TILE_BLIT_DEFINES_SVH

// Same-cycle implication: when ante holds, cons holds on that edge.
`define PFTB_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define PFTB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/pftb_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pftb_pkg
// Geometry constants, opcodes, states and controller/datapath interface types.
// ---------------------------------------------------------------------------
package pftb_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_SIZE    = SCREEN_WIDTH * PAGE_COUNT;
	localparam int ADDR_W        = $clog2(STORE_SIZE);

	// Input field widths
	localparam int OP_W    = 2;
	localparam int ORG_W   = 9;
	localparam int TW_W    = 8;
	localparam int ROW_W   = 8;
	localparam int BCOL_W  = 5;
	localparam int DATA_W  = 8;
	localparam int RIDX_W  = 10;
	localparam int STEP_W  = 3;

	// Screen coordinate width: 9-bit signed origin plus an 8-bit offset
	localparam int COORD_W = 11;
	// Width used to range-check a read index against the store size; one bit
	// above both so that STORE_SIZE itself fits
	localparam int IDX_W   = ((ADDR_W > RIDX_W) ? ADDR_W : RIDX_W) + 1;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_PIXEL = 2'd1,
		OP_TILE  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_CALC,
		ST_RD,
		ST_WR,
		ST_FETCH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic latch;     // capture the input word
		logic clr_wr;    // write zero at the sweep address, advance sweep
		logic calc_load; // register address, mask and value of current pixel
		logic mem_rd;    // read store at the held address
		logic mem_wr;    // write modified byte back
		logic step_inc;  // advance to next tile bit
		logic out_load;  // load the result register
	} cmd_t;

	typedef struct packed {
		logic stop;      // current tile bit lies beyond the tile width
		logic hit;       // current pixel lies on screen
		logic last;      // current step is the final one of the item
		logic clr_last;  // sweep is at the final address
	} sts_t;

endpackage

[design/pftb_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pftb_datapath
// Operand latch, pixel address math, frame store and result register.
// ---------------------------------------------------------------------------
module pftb_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pftb_pkg::cmd_t                cmd,
	output pftb_pkg::sts_t                sts,
	input  logic [pftb_pkg::OP_W-1:0]     op,
	input  logic signed [pftb_pkg::ORG_W-1:0] origin_x,
	input  logic signed [pftb_pkg::ORG_W-1:0] origin_y,
	input  logic [pftb_pkg::TW_W-1:0]     tile_width,
	input  logic [pftb_pkg::ROW_W-1:0]    tile_line,
	input  logic [pftb_pkg::BCOL_W-1:0]   byte_column,
	input  logic [pftb_pkg::DATA_W-1:0]   tile_data,
	input  logic [pftb_pkg::RIDX_W-1:0]   read_index,
	output logic [pftb_pkg::DATA_W-1:0]   read_data,
	output logic                          is_read
);
	import pftb_pkg::*;

	localparam logic signed [COORD_W-1:0] SW_S = COORD_W'(SCREEN_WIDTH);
	localparam logic signed [COORD_W-1:0] SH_S = COORD_W'(SCREEN_HEIGHT);

	logic [DATA_W-1:0] mem [STORE_SIZE];

	op_t                      op_q;
	logic signed [ORG_W-1:0]  ox_q, oy_q;
	logic [TW_W-1:0]          tw_q;
	logic [ROW_W-1:0]         row_q;
	logic [BCOL_W-1:0]        bcol_q;
	logic [DATA_W-1:0]        data_q;
	logic                     rng_q;
	logic [STEP_W-1:0]        step_q;
	logic [ADDR_W-1:0]        addr_q;
	logic [ADDR_W-1:0]        clr_cnt_q;
	logic [DATA_W-1:0]        mask_q;
	logic                     val_q;
	logic [DATA_W-1:0]        rdata_q;
	logic [DATA_W-1:0]        read_data_q;
	logic                     is_read_q;

	logic                     is_tile;
	logic [TW_W-1:0]          tcol;
	logic [TW_W-1:0]          x_off;
	logic [ROW_W-1:0]         y_off;
	logic signed [COORD_W-1:0] x_s, y_s;
	logic [COORD_W-5:0]       pg;
	logic [ADDR_W-1:0]        pix_idx;
	logic                     pix_val;
	logic [IDX_W-1:0]         ridx_ext;
	logic [DATA_W-1:0]        wr_byte;

	assign is_tile = (op_q == OP_TILE);
	assign tcol    = {bcol_q, step_q};
	assign x_off   = is_tile ? tcol : '0;
	assign y_off   = is_tile ? row_q : '0;
	assign x_s     = COORD_W'(ox_q) + $signed({3'b000, x_off});
	assign y_s     = COORD_W'(oy_q) + $signed({3'b000, y_off});
	assign pg      = y_s[COORD_W-2:3];
	assign pix_idx = ADDR_W'(32'(pg) * 32'(SCREEN_WIDTH) + 32'(x_s[COORD_W-2:0]));
	assign pix_val = is_tile ? data_q[3'd7 - step_q] : data_q[0];
	assign ridx_ext = IDX_W'(read_index);
	assign wr_byte = val_q ? (rdata_q | mask_q) : (rdata_q & ~mask_q);

	assign sts.stop     = is_tile && (tcol >= tw_q);
	assign sts.hit      = !x_s[COORD_W-1] && (x_s < SW_S) && !y_s[COORD_W-1] && (y_s < SH_S);
	assign sts.last     = !is_tile || (step_q == STEP_W'(7));
	assign sts.clr_last = (clr_cnt_q == ADDR_W'(STORE_SIZE - 1));

	// Capture operands; step counter restarts with each word
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= op_t'(op);
			ox_q   <= origin_x;
			oy_q   <= origin_y;
			tw_q   <= tile_width;
			row_q  <= tile_line;
			bcol_q <= byte_column;
			data_q <= tile_data;
			rng_q  <= (ridx_ext < IDX_W'(STORE_SIZE));
			addr_q <= ridx_ext[ADDR_W-1:0];
			step_q <= '0;
		end else begin
			if (cmd.step_inc) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.calc_load) begin
				addr_q <= pix_idx;
				mask_q <= DATA_W'(1) << y_s[2:0];
				val_q  <= pix_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= sts.clr_last ? '0 : clr_cnt_q + ADDR_W'(1);
		end
	end

	// Frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem[clr_cnt_q] <= '0;
		end else if (cmd.mem_wr) begin
			mem[addr_q] <= wr_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rdata_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			read_data_q <= ((op_q == OP_READ) && rng_q) ? rdata_q : '0;
			is_read_q   <= (op_q == OP_READ);
		end
	end

	assign read_data = read_data_q;
	assign is_read   = is_read_q;

endmodule

[design/pftb_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pftb_ctrl
// Sequencer for clear sweeps, byte reads, pixel read-modify-write steps and result hand-off.
// ---------------------------------------------------------------------------
`include "page_framebuffer_tile_blit_defines.svh"

module pftb_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [pftb_pkg::OP_W-1:0] op,
	output logic                      out_valid,
	input  logic                      out_stall,
	output pftb_pkg::cmd_t            cmd,
	input  pftb_pkg::sts_t            sts
);
	import pftb_pkg::*;

	state_t state_q, state_d;
	logic   out_vld_q;
	logic   accept;

	assign accept = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (op_t'(op))
						OP_CLEAR: state_d = ST_CLEAR;
						OP_READ:  state_d = ST_FETCH;
						default:  state_d = ST_CALC;
					endcase
				end
			end
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_DONE;
			end
			ST_CALC: begin
				if (sts.stop) state_d = ST_DONE;
				else if (sts.hit) state_d = ST_RD;
				else if (sts.last) state_d = ST_DONE;
			end
			ST_RD:    state_d = ST_WR;
			ST_WR:    state_d = sts.last ? ST_DONE : ST_CALC;
			ST_FETCH: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_vld_q || !out_stall) state_d = ST_IDLE;
			end
			default:  state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.latch     = accept;
		cmd.clr_wr    = (state_q == ST_INIT) || (state_q == ST_CLEAR);
		cmd.calc_load = (state_q == ST_CALC) && !sts.stop && sts.hit;
		cmd.mem_rd    = (state_q == ST_RD) || (state_q == ST_FETCH);
		cmd.mem_wr    = (state_q == ST_WR);
		cmd.step_inc  = ((state_q == ST_CALC) && !sts.stop && !sts.hit && !sts.last) ||
		                ((state_q == ST_WR) && !sts.last);
		cmd.out_load  = (state_q == ST_DONE) && (!out_vld_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			out_vld_q <= cmd.out_load || (out_vld_q && out_stall);
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_vld_q;

	`PFTB_ASSERT_NEXT(a_accept_blocks, clk, arst_n, in_valid && !in_stall, in_stall,
		"input taken again before the current word finished")
	`PFTB_ASSERT_NEXT(a_rd_then_wr, clk, arst_n, state_q == ST_RD, state_q == ST_WR,
		"pixel read not followed by its write-back")
	`PFTB_ASSERT_NOW(a_load_free, clk, arst_n, cmd.out_load, !out_vld_q || !out_stall,
		"result loaded over an unaccepted result")
	`PFTB_ASSERT_NOW(a_step_bound, clk, arst_n, cmd.step_inc, !sts.last,
		"tile step advanced past the final bit")
	`PFTB_ASSERT_NOW(a_one_writer, clk, arst_n, cmd.clr_wr, !cmd.mem_wr && !cmd.latch,
		"clear sweep overlaps another store access")

endmodule

[design/page_framebuffer_tile_blit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_framebuffer_tile_blit
// Monochrome page-format frame store with pixel, tile-byte, clear and read ops.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one word per operation; output
//   channel (out_valid/out_stall) returns exactly one word per operation,
//   in order. Only read operations carry a frame byte (is_read = 1).
//   One word is in work at a time; a finished result sits in the output
//   register while the next input word is taken.
//   Each word runs through these steps before the block returns to idle:
//     read byte     store read, then result load
//     single pixel  address check; if on screen, read and write-back of the
//                   column byte; then result load
//     tile byte     per bit: address check, plus read and write-back when on
//                   screen; stops early where the tile width ends the byte
//     clear         one zero write per store byte, then result load
//   The pixel loop does a read-modify-write of one column byte per bit on a
//   single-port store.
//   Reset: after arst_n releases, a clearing pass zeroes all STORE_SIZE (1024)
//   bytes of the store, one byte per cycle, with in_stall high throughout.
//   If the receiver stalls, the result holds in the output register and the
//   block finishes the next word, then waits before loading its result.
// ---------------------------------------------------------------------------
module page_framebuffer_tile_blit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pftb_pkg::OP_W-1:0]         op,
	input  logic signed [pftb_pkg::ORG_W-1:0] origin_x,
	input  logic signed [pftb_pkg::ORG_W-1:0] origin_y,
	input  logic [pftb_pkg::TW_W-1:0]         tile_width,
	input  logic [pftb_pkg::ROW_W-1:0]        tile_line,
	input  logic [pftb_pkg::BCOL_W-1:0]       byte_column,
	input  logic [pftb_pkg::DATA_W-1:0]       tile_data,
	input  logic [pftb_pkg::RIDX_W-1:0]       read_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pftb_pkg::DATA_W-1:0]       read_data,
	output logic                              is_read
);
	import pftb_pkg::*;

	// Commands from the sequencer, status back from the datapath
	cmd_t cmd;
	sts_t sts;

	// Sequencer: owns both handshakes and walks each word through its steps
	pftb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath: operand hold, address math, frame store, result register
	pftb_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.tile_width  (tile_width),
		.tile_line   (tile_line),
		.byte_column (byte_column),
		.tile_data   (tile_data),
		.read_index  (read_index),
		.read_data   (read_data),
		.is_read     (is_read)
	);

endmodule
